### rtl/lrps_pkg.sv
package lrps_pkg;

  // Default sizes for the top level parameters.
  localparam int QUEUE_SLOTS_DEF = 8;
  localparam int RELAY_COUNT_DEF = 2;

  // Fixed field widths.
  localparam int TIME_W    = 32;
  localparam int LEN_W     = 10;
  localparam int COIL_W    = 4;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Both phase lengths come out of reset at ten milliseconds.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  // Depth of the word queue between the front and the back.
  localparam int ITEM_DEPTH = 2;

  // Operation codes of the input word.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_PULSE_LEN = 1'b0;
  localparam logic REG_GAP_LEN   = 1'b1;

  typedef enum logic [1:0] {
    CLS_TICK,
    CLS_REQ,
    CLS_SKIP
  } item_cls_t;

  typedef struct packed {
    item_cls_t         cls;
    logic [TIME_W-1:0] now_ms;
    logic              relay;
    logic              want_set;
    logic              force_req;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } fifo_wr_t;

endpackage

### rtl/latching_relay_pulse_sequencer_unit.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// in       | in_valid / in_stall | in_operation, in_now_ms, in_relay,
//          |                     | in_want_set, in_force_req
// out      | out_valid/out_stall | out_coil_lines, out_busy_res, out_relay0_set,
//          |                     | out_relay1_set, out_dropped
// config   | APB psel/penable    | paddr, pwdata, prdata (pulse and gap lengths)
//
// One word is taken per cycle sustained while out_stall stays low. A word
// accepted sits in the two-entry word queue, is executed by the state update
// in the back, and its result word is then held in the result register.
// Reset is synchronous; afterwards the pulse ring already holds one reset-coil
// pulse per relay that fits in it and both lengths read ten milliseconds.
// in_stall rises only when the two-entry word queue is full; out_stall holds
// a waiting result and stops the back, and the front keeps accepting words
// until the queue fills.
module latching_relay_pulse_sequencer_unit #(
  parameter int QUEUE_SLOTS = lrps_pkg::QUEUE_SLOTS_DEF,
  parameter int RELAY_COUNT = lrps_pkg::RELAY_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [lrps_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            in_relay,
  input  logic                            in_want_set,
  input  logic                            in_force_req,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrps_pkg::COIL_W-1:0]     out_coil_lines,
  output logic                            out_busy_res,
  output logic                            out_relay0_set,
  output logic                            out_relay1_set,
  output logic                            out_dropped,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lrps_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lrps_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lrps_pkg::*;

  logic [LEN_W-1:0] pulse_len_r, pulse_len_nxt;
  logic [LEN_W-1:0] gap_len_r, gap_len_nxt;
  logic             cfg_wr;
  logic             reg_sel;

  fifo_wr_t         fifo_wr;
  logic             fifo_full;
  logic             rd_valid;
  item_t            rd_item;
  logic             rd_pop;

  // Configuration registers. The register is picked by the word address bit;
  // byte offset bits are ignored. Writes are meant to come only while no word
  // is in flight.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    pulse_len_nxt = pulse_len_r;
    gap_len_nxt   = gap_len_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_PULSE_LEN: pulse_len_nxt = pwdata[LEN_W-1:0];
        REG_GAP_LEN:   gap_len_nxt   = pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PULSE_LEN: prdata = APB_DATA_W'(pulse_len_r);
      REG_GAP_LEN:   prdata = APB_DATA_W'(gap_len_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_len_r <= LEN_RESET;
      gap_len_r   <= LEN_RESET;
    end else begin
      pulse_len_r <= pulse_len_nxt;
      gap_len_r   <= gap_len_nxt;
    end
  end

  // The front classifies each word (tick, request, or request for a missing
  // relay) and pushes it into the word queue.
  lrps_front #(
    .RELAY_COUNT(RELAY_COUNT)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_now_ms    (in_now_ms),
    .in_relay     (in_relay),
    .in_want_set  (in_want_set),
    .in_force_req (in_force_req),
    .fifo_full    (fifo_full),
    .fifo_wr      (fifo_wr)
  );

  lrps_item_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_wr   (fifo_wr),
    .fifo_full (fifo_full),
    .rd_valid  (rd_valid),
    .rd_item   (rd_item),
    .rd_pop    (rd_pop)
  );

  // The back owns the pulse ring, the remembered positions and the pulse and gap
  // timer, and applies one word per cycle into its result register unless stalled.
  lrps_back #(
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .RELAY_COUNT(RELAY_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rd_valid       (rd_valid),
    .rd_item        (rd_item),
    .rd_pop         (rd_pop),
    .pulse_len      (pulse_len_r),
    .gap_len        (gap_len_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coil_lines (out_coil_lines),
    .out_busy_res   (out_busy_res),
    .out_relay0_set (out_relay0_set),
    .out_relay1_set (out_relay1_set),
    .out_dropped    (out_dropped)
  );

endmodule

### rtl/lrps_front.sv
module lrps_front #(
  parameter int RELAY_COUNT = lrps_pkg::RELAY_COUNT_DEF
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [lrps_pkg::TIME_W-1:0] in_now_ms,
  input  logic                      in_relay,
  input  logic                      in_want_set,
  input  logic                      in_force_req,
  input  logic                      fifo_full,
  output lrps_pkg::fifo_wr_t        fifo_wr
);
  import lrps_pkg::*;

  logic relay_ok;

  // A request for a relay that does not exist is marked as a skip here and only
  // produces a status word at the back.
  assign relay_ok = (RELAY_COUNT > 1) || (in_relay == 1'b0);
  assign in_stall = fifo_full;

  always_comb begin
    fifo_wr.push           = in_valid && !fifo_full;
    fifo_wr.item.now_ms    = in_now_ms;
    fifo_wr.item.relay     = in_relay;
    fifo_wr.item.want_set  = in_want_set;
    fifo_wr.item.force_req = in_force_req;
    if (in_operation == OP_TICK) begin
      fifo_wr.item.cls = CLS_TICK;
    end else if (relay_ok) begin
      fifo_wr.item.cls = CLS_REQ;
    end else begin
      fifo_wr.item.cls = CLS_SKIP;
    end
  end

endmodule

### rtl/lrps_item_fifo.sv
module lrps_item_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  lrps_pkg::fifo_wr_t fifo_wr,
  output logic               fifo_full,
  output logic               rd_valid,
  output lrps_pkg::item_t    rd_item,
  input  logic               rd_pop
);
  import lrps_pkg::*;

  localparam int IDX_W = $clog2(ITEM_DEPTH);

  item_t            mem_r [ITEM_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W:0]   count_r, count_nxt;

  assign fifo_full = (count_r == (IDX_W+1)'(ITEM_DEPTH));
  assign rd_valid  = (count_r != '0);
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (fifo_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(ITEM_DEPTH-1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (rd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(ITEM_DEPTH-1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (fifo_wr.push && !rd_pop) begin
      count_nxt = count_r + (IDX_W+1)'(1);
    end else if (!fifo_wr.push && rd_pop) begin
      count_nxt = count_r - (IDX_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr.push) begin
      mem_r[wr_ptr_r] <= fifo_wr.item;
    end
  end

endmodule

### rtl/lrps_back.sv
module lrps_back #(
  parameter int QUEUE_SLOTS = lrps_pkg::QUEUE_SLOTS_DEF,
  parameter int RELAY_COUNT = lrps_pkg::RELAY_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_valid,
  input  lrps_pkg::item_t            rd_item,
  output logic                       rd_pop,
  input  logic [lrps_pkg::LEN_W-1:0] pulse_len,
  input  logic [lrps_pkg::LEN_W-1:0] gap_len,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lrps_pkg::COIL_W-1:0] out_coil_lines,
  output logic                       out_busy_res,
  output logic                       out_relay0_set,
  output logic                       out_relay1_set,
  output logic                       out_dropped
);
  import lrps_pkg::*;

  localparam int PTR_W      = $clog2(QUEUE_SLOTS);
  localparam int CODE_W     = $clog2(2 * RELAY_COUNT);
  localparam int INIT_CODES = (RELAY_COUNT < QUEUE_SLOTS - 1) ? RELAY_COUNT : QUEUE_SLOTS - 1;

  logic [CODE_W-1:0]      ring_r [QUEUE_SLOTS];
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [RELAY_COUNT-1:0] rem_pos_r, rem_pos_nxt;
  logic                   active_r, active_nxt;
  logic                   in_gap_r, in_gap_nxt;
  logic [CODE_W-1:0]      coil_code_r, coil_code_nxt;
  logic [TIME_W-1:0]      phase_start_r, phase_start_nxt;

  logic                   out_valid_r;
  logic [COIL_W-1:0]      out_coil_lines_r, coil_nxt;
  logic                   out_busy_res_r, busy_nxt;
  logic                   out_relay0_set_r, relay0_nxt;
  logic                   out_relay1_set_r, relay1_nxt;
  logic                   out_dropped_r, dropped_nxt;

  logic                   fire;
  logic                   push_en;
  logic [CODE_W-1:0]      push_code;
  logic [PTR_W-1:0]       tail_adv;
  logic [PTR_W-1:0]       head_adv;
  logic [RELAY_COUNT-1:0] hit_vec;
  logic                   rem_cur;
  logic [TIME_W-1:0]      elapsed;
  logic [CODE_W-1:0]      flip_code;

  // A word is executed when the result register is free or being emptied.
  assign fire   = rd_valid && (!out_valid_r || !out_stall);
  assign rd_pop = fire;

  assign push_code = CODE_W'({rd_item.relay, rd_item.want_set});
  assign tail_adv  = (tail_r == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : tail_r + PTR_W'(1);
  assign head_adv  = (head_r == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : head_r + PTR_W'(1);
  assign elapsed   = rd_item.now_ms - phase_start_r;
  assign rem_cur   = |(rem_pos_r & hit_vec);

  always_comb begin
    for (int k = 0; k < RELAY_COUNT; k++) begin
      hit_vec[k] = (int'(rd_item.relay) == k);
    end
  end

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    rem_pos_nxt     = rem_pos_r;
    active_nxt      = active_r;
    in_gap_nxt      = in_gap_r;
    coil_code_nxt   = coil_code_r;
    phase_start_nxt = phase_start_r;
    dropped_nxt     = 1'b0;
    push_en         = 1'b0;
    if (fire) begin
      unique case (rd_item.cls)
        CLS_REQ: begin
          if (rd_item.force_req || (rem_cur != rd_item.want_set)) begin
            rem_pos_nxt = (rem_pos_r & ~hit_vec) | (hit_vec & {RELAY_COUNT{rd_item.want_set}});
            if (tail_adv == head_r) begin
              dropped_nxt = 1'b1;
            end else begin
              push_en  = 1'b1;
              tail_nxt = tail_adv;
            end
          end
        end
        CLS_TICK: begin
          if (active_r) begin
            if (!in_gap_r && (elapsed >= TIME_W'(pulse_len))) begin
              in_gap_nxt      = 1'b1;
              phase_start_nxt = rd_item.now_ms;
            end else if (in_gap_r && (elapsed >= TIME_W'(gap_len))) begin
              active_nxt = 1'b0;
            end
          end else if (head_r != tail_r) begin
            coil_code_nxt   = ring_r[head_r];
            head_nxt        = head_adv;
            active_nxt      = 1'b1;
            in_gap_nxt      = 1'b0;
            phase_start_nxt = rd_item.now_ms;
          end
        end
        CLS_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Coil line index is the pulse code with its low bit inverted: the set
  // coil of relay k sits at bit 2k and its reset coil at bit 2k+1.
  always_comb begin
    flip_code  = coil_code_nxt ^ CODE_W'(1);
    relay1_nxt = 1'b0;
    for (int b = 0; b < COIL_W; b++) begin
      coil_nxt[b] = active_nxt && !in_gap_nxt && (int'(flip_code) == b);
    end
    for (int k = 0; k < RELAY_COUNT; k++) begin
      if (k == 1) begin
        relay1_nxt = rem_pos_nxt[k];
      end
    end
    relay0_nxt = rem_pos_nxt[0];
    busy_nxt   = active_nxt || (head_nxt != tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= PTR_W'(INIT_CODES);
      rem_pos_r     <= '0;
      active_r      <= 1'b0;
      in_gap_r      <= 1'b0;
      coil_code_r   <= '0;
      phase_start_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      rem_pos_r     <= rem_pos_nxt;
      active_r      <= active_nxt;
      in_gap_r      <= in_gap_nxt;
      coil_code_r   <= coil_code_nxt;
      phase_start_r <= phase_start_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reset preloads one reset-coil pulse per relay that fits in the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUEUE_SLOTS; k++) begin
        ring_r[k] <= (k < INIT_CODES) ? CODE_W'(2 * k) : '0;
      end
    end else if (push_en) begin
      ring_r[tail_r] <= push_code;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_coil_lines_r <= coil_nxt;
      out_busy_res_r   <= busy_nxt;
      out_relay0_set_r <= relay0_nxt;
      out_relay1_set_r <= relay1_nxt;
      out_dropped_r    <= dropped_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coil_lines = out_coil_lines_r;
  assign out_busy_res   = out_busy_res_r;
  assign out_relay0_set = out_relay0_set_r;
  assign out_relay1_set = out_relay1_set_r;
  assign out_dropped    = out_dropped_r;

`ifndef SYNTHESIS
  a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_coil_lines_r))
    else $error("more than one coil line driven");

  a_idle_no_coil: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_busy_res_r) |-> (out_coil_lines_r == '0))
    else $error("coil line high while sequencer reports idle");

  a_drop_only_req: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (rd_item.cls != CLS_REQ)) |=> !out_dropped_r)
    else $error("drop flagged on a word that is not a request");

  a_drop_ring_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && dropped_nxt) |-> ((tail_adv == head_r) && !push_en))
    else $error("drop flagged while the ring had room");
`endif

endmodule
